// ----- src/aodbc_pkg.sv -----
// Package for absorbance OD block: widths, constants, kind codes, shared types.
// No dependencies.
package aodbc_pkg;

    localparam int CHANNELS_DEF   = 4;
    localparam int COUNT_BITS_DEF = 24;
    localparam int LOG_FRAC       = 24;

    localparam logic [31:0] LOG10_2_Q32 = 32'd1292913986;
    localparam logic [23:0] PATH_RESET  = 24'd65536;
    localparam logic [31:0] A260_RESET  = 32'd3276800;
    localparam logic [15:0] BLANK_RESET = 16'd1;

    localparam logic signed [39:0] FSUM_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] FSUM_MIN = -40'sh80_0000_0000;
    localparam logic signed [47:0] CONC_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] CONC_MIN = -48'sh8000_0000_0000;

    typedef enum logic [1:0] {
        KIND_BLANK   = 2'd0,
        KIND_MEASURE = 2'd1,
        KIND_CLEAR   = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    localparam logic [1:0] CH_260 = 2'd1;

    localparam logic [1:0] CFG_PATH  = 2'd0;
    localparam logic [1:0] CFG_A260  = 2'd1;
    localparam logic [1:0] CFG_BLANK = 2'd2;

    // Request/response between sequencer and log unit.
    typedef struct packed {
        logic        start;
        logic [31:0] x;
    } log_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] res;
    } log_rsp_t;

    // Request/response for the shared divider.
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [39:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } div_rsp_t;

endpackage

// ----- src/aodbc_log2.sv -----
// Iterative log2 unit, squaring method, one fraction bit per cycle.
// Depends on aodbc_pkg.
module aodbc_log2 (
    input  logic                clk,
    input  logic                rst_n,
    input  aodbc_pkg::log_req_t req,
    output aodbc_pkg::log_rsp_t rsp
);

    logic [32:0]        m_reg,   m_next;
    logic signed [31:0] res_reg, res_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [4:0]         lz;
    logic [65:0]        sq;
    logic [34:0]        sqs;

    // leading one position of x
    always_comb
    begin
        lz = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (req.x[i])
                lz = 5'(i);
        end
    end

    assign sq  = m_reg * m_reg;
    assign sqs = sq[65:31];

    always_comb
    begin
        m_next    = m_reg;
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            m_next    = 33'(req.x << (5'd31 - lz));
            res_next  = 32'(lz);
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (sqs[32])
            begin
                m_next   = sqs[33:1];
                res_next = {res_reg[30:0], 1'b1};
            end
            else
            begin
                m_next   = sqs[32:0];
                res_next = {res_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(aodbc_pkg::LOG_FRAC - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg   <= m_next;
        res_reg <= res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

// ----- src/aodbc_div.sv -----
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on aodbc_pkg.
module aodbc_div (
    input  logic                clk,
    input  logic                rst_n,
    input  aodbc_pkg::div_req_t req,
    output aodbc_pkg::div_rsp_t rsp
);

    logic [63:0] q_reg, q_next;
    logic [40:0] r_reg, r_next;
    logic [39:0] d_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [40:0] trial;
    logic [40:0] diff;

    assign trial = {r_reg[39:0], q_reg[63]};
    assign diff  = trial - {1'b0, d_reg};

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            q_next    = req.num;
            r_next    = '0;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[40])
            begin
                r_next = diff;
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (req.start)
            d_reg <= req.den;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = q_reg;

endmodule

// ----- src/absorbance_od_with_blank_correction.sv -----
// Top level of the absorbance (optical density) block with blank correction.
// Depends on aodbc_pkg, aodbc_log2, aodbc_div.
//
// Usage:
//  s_axis_* carries one transaction per channel measurement: kind, channel
//  and six detector counts in tdata, has_air in tuser. m_axis_* returns one
//  result per blank or measure transaction: OD, concentration, flags.
//  Clear transactions reset all per-channel factor state and return nothing.
//  cfg_* writes path_length (0), a260_unit (1), blank_count (2) while idle.
// Throughput:
//  One item at a time. A shared log2 unit (24 squaring steps plus load) runs
//  four or eight times (none on a zero count), a shared 64-step divider runs
//  at most twice per item (the factor for a blank; the mean and the
//  concentration for a measure), and one shared multiplier does the scaling,
//  next to a narrow product for the concentration overflow check.
//  s_axis_tready is high only when the sequencer is idle and no result is
//  pending.
// Reset: rst_n sets control/config registers to defaults, factor state to 0.
// Stall: the result waits in an output register while m_axis_tready is low;
//  the next input is taken once the result has been handed over.
module absorbance_od_with_blank_correction #(
    parameter int CHANNELS   = aodbc_pkg::CHANNELS_DEF,
    parameter int COUNT_BITS = aodbc_pkg::COUNT_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // kind[1:0], channel[3:2], base_sample, base_reference, meas_sample,
    // meas_reference, air_sample, air_reference (COUNT_BITS each, upward)
    input  logic [((4 + 6 * COUNT_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input  logic         s_axis_tuser,   // has_air
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // optical_density[31:0], concentration[79:32], concentration_valid[80],
    // fault[81], zero pad to 88
    output logic [87:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int CB    = COUNT_BITS;
    localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_LOG   = 11'b00000000010,
        S_LWAIT = 11'b00000000100,
        S_MUL   = 11'b00000001000,
        S_FDIV  = 11'b00000010000,
        S_FACC  = 11'b00000100000,
        S_MDIV  = 11'b00001000000,
        S_CORR  = 11'b00010000000,
        S_CDIV  = 11'b00100000000,
        S_CMUL  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [23:0] path_reg;
    logic [31:0] a260_reg;
    logic [15:0] bcount_reg;

    // per-channel state
    logic signed [39:0] fsum_reg  [CHANNELS];
    logic [15:0]        bidx_reg  [CHANNELS];
    logic [15:0]        bused_reg [CHANNELS];

    // captured item
    logic [1:0]    kind_reg;
    logic [1:0]    ch_reg;
    logic [CB-1:0] cnt_reg [6];
    logic          air_reg;

    // work registers
    logic [2:0]         li_reg;        // log index 0..4
    logic signed [33:0] dsum_reg;      // summed logs
    logic signed [31:0] ods_reg, oda_reg;
    logic               pass_reg;      // 0 sample OD, 1 air OD
    logic signed [31:0] od_reg;
    logic [47:0]        conc_reg;
    logic               cval_reg, fault_reg;
    logic signed [31:0] fact_reg;
    logic [63:0]        t_reg;

    logic [87:0] out_reg;
    logic        ovalid_reg;

    aodbc_pkg::log_req_t lreq;
    aodbc_pkg::log_rsp_t lrsp;
    aodbc_pkg::div_req_t dreq;
    aodbc_pkg::div_rsp_t drsp;

    aodbc_log2 u_log (.clk(clk), .rst_n(rst_n), .req(lreq), .rsp(lrsp));
    aodbc_div  u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic s_acc, m_acc;
    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign m_acc         = m_axis_tvalid && m_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = out_reg;

    logic          chok;
    logic [CHW-1:0] chi;
    assign chok = 32'(ch_reg) < CHANNELS;
    assign chi  = CHW'(ch_reg);

    // operand for current log step: pass 0 bs,mr,br,ms; pass 1 bs,ar,br,as
    logic [CB-1:0] lop;
    always_comb
    begin
        case (li_reg[1:0])
            2'd0:    lop = cnt_reg[0];
            2'd1:    lop = pass_reg ? cnt_reg[5] : cnt_reg[3];
            2'd2:    lop = cnt_reg[1];
            default: lop = pass_reg ? cnt_reg[4] : cnt_reg[2];
        endcase
    end

    // shared multiplier: selects operands by state
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    always_comb
    begin
        mul_a = 33'sd0;
        mul_b = 33'sd0;
        case (state_reg)
            S_MUL:
            begin
                mul_a = 33'(dsum_reg);
                mul_b = {1'b0, aodbc_pkg::LOG10_2_Q32};
            end
            S_CORR:
            begin
                mul_a = 33'(oda_reg);
                mul_b = 33'(fact_reg);
            end
            S_CMUL:
            begin
                mul_a = {7'd0, t_reg[25:0]};
                mul_b = {1'b0, a260_reg};
            end
            default:
            begin
                mul_a = 33'sd0;
                mul_b = 33'sd0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // round half away from zero of product >> 40 (OD) or >> 16 (correction)
    logic        p_neg;
    logic [65:0] p_mag;
    logic [41:0] rnd40;
    logic [65:0] rnd16;
    assign p_neg = mul_p[65];
    assign p_mag = p_neg ? 66'(-mul_p) : 66'(mul_p);
    assign rnd40 = 42'((p_mag + (66'd1 << 39)) >> 40);
    assign rnd16 = 66'((p_mag + (66'd1 << 15)) >> 16);

    // t < 2^51, so (t>>26) fits 25 bits; used for the overflow check in S_CMUL
    logic [39:0] hi_a;
    logic [56:0] hi_prod;
    assign hi_prod = 57'(t_reg[50:26]) * 57'(a260_reg);
    assign hi_a    = hi_prod[39:0];

    logic any_zero;
    always_comb
    begin
        any_zero = (cnt_reg[0] == '0) || (cnt_reg[1] == '0) ||
                   (cnt_reg[2] == '0) || (cnt_reg[3] == '0) ||
                   (air_reg && ((cnt_reg[4] == '0) || (cnt_reg[5] == '0)));
    end

    logic [31:0] ods_mag, oda_mag, od_mag;
    assign ods_mag = ods_reg[31] ? 32'(-ods_reg) : 32'(ods_reg);
    assign oda_mag = oda_reg[31] ? 32'(-oda_reg) : 32'(oda_reg);
    assign od_mag  = od_reg[31]  ? 32'(-od_reg)  : 32'(od_reg);

    logic [39:0] fsum_mag;
    assign fsum_mag = (chok && fsum_reg[chi][39]) ? 40'(-fsum_reg[chi])
                    : (chok ? 40'(fsum_reg[chi]) : 40'd0);

    logic signed [40:0] fadd;
    logic signed [33:0] q_sat;
    logic               q_neg;
    logic signed [65:0] corr_diff;

    always_comb
    begin
        q_neg        = ods_reg[31] != oda_reg[31];
        if (drsp.quo > 64'd2147483648)
            q_sat = q_neg ? -34'sd2147483648 : 34'sd2147483647;
        else if (!q_neg && drsp.quo == 64'd2147483648)
            q_sat = 34'sd2147483647;
        else
            q_sat = q_neg ? -34'(drsp.quo[32:0]) : 34'(drsp.quo[32:0]);
        // new blank factor goes straight into the channel sum
        fadd = (chok ? 41'(fsum_reg[chi]) : 41'sd0) + 41'(q_sat);
        corr_diff = 66'(ods_reg) - (p_neg ? -66'(rnd16) : 66'(rnd16));
    end

    always_comb
    begin
        state_next = state_reg;
        lreq.start = 1'b0;
        lreq.x     = 32'(lop);
        dreq.start = 1'b0;
        dreq.num   = '0;
        dreq.den   = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    if (s_axis_tdata[1:0] == aodbc_pkg::KIND_BLANK ||
                        s_axis_tdata[1:0] == aodbc_pkg::KIND_MEASURE)
                        state_next = S_LOG;
                end
            end
            S_LOG:
            begin
                if (any_zero)
                    state_next = S_OUT;
                else
                begin
                    lreq.start = 1'b1;
                    state_next = S_LWAIT;
                end
            end
            S_LWAIT:
            begin
                if (lrsp.done)
                    state_next = (li_reg[1:0] == 2'd3) ? S_MUL : S_LOG;
            end
            S_MUL:
            begin
                if (!pass_reg && air_reg)
                    state_next = S_LOG;
                else if (kind_reg == aodbc_pkg::KIND_BLANK)
                    state_next = S_FDIV;
                else if (air_reg && chok && bused_reg[chi] != 16'd0)
                    state_next = S_MDIV;
                else if (air_reg)
                    state_next = S_CORR;
                else
                    state_next = S_OUT;
            end
            S_FDIV:
            begin
                // the blank factor only needs dividing when it is summed
                if (!air_reg || !chok || bidx_reg[chi] >= bcount_reg || oda_reg == 32'sd0)
                    state_next = S_OUT;
                else
                begin
                    dreq.start = 1'b1;
                    dreq.num   = {16'd0, ods_mag, 16'd0};
                    dreq.den   = 40'(oda_mag);
                    state_next = S_FACC;
                end
            end
            S_FACC:
            begin
                if (drsp.done)
                    state_next = S_OUT;
            end
            S_MDIV:
            begin
                if (!dreq.start && drsp.done)
                    state_next = S_CORR;
                else if (fact_reg == 32'sd1)
                begin
                    dreq.start = 1'b1;
                    dreq.num   = {24'd0, fsum_mag};
                    dreq.den   = {24'd0, bused_reg[chi]};
                end
            end
            S_CORR:
            begin
                if (ch_reg == aodbc_pkg::CH_260)
                    state_next = S_CDIV;
                else
                    state_next = S_OUT;
            end
            S_CDIV:
            begin
                if (od_reg == 32'sd0 || path_reg == 24'd0)
                    state_next = S_OUT;
                else if (!dreq.start && drsp.done)
                    state_next = S_CMUL;
                else if (t_reg == 64'd1)
                begin
                    dreq.start = 1'b1;
                    dreq.num   = 64'({od_mag, 16'd0}) * 64'd10;
                    dreq.den   = 40'(path_reg);
                end
            end
            S_CMUL:
                state_next = S_OUT;
            S_OUT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            path_reg   <= aodbc_pkg::PATH_RESET;
            a260_reg   <= aodbc_pkg::A260_RESET;
            bcount_reg <= aodbc_pkg::BLANK_RESET;
            for (int c = 0; c < CHANNELS; c++)
            begin
                fsum_reg[c]  <= '0;
                bidx_reg[c]  <= '0;
                bused_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    aodbc_pkg::CFG_PATH:  path_reg   <= cfg_data[23:0];
                    aodbc_pkg::CFG_A260:  a260_reg   <= cfg_data;
                    aodbc_pkg::CFG_BLANK: bcount_reg <= cfg_data[15:0];
                    default:              ;
                endcase
            end
            if (m_acc)
                ovalid_reg <= 1'b0;
            if (state_reg == S_OUT)
                ovalid_reg <= 1'b1;
            if (s_acc && s_axis_tdata[1:0] == aodbc_pkg::KIND_CLEAR)
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    fsum_reg[c]  <= '0;
                    bidx_reg[c]  <= '0;
                    bused_reg[c] <= '0;
                end
            end
            if (state_reg == S_FACC && drsp.done && chok)
            begin
                if (fadd > 41'(aodbc_pkg::FSUM_MAX))
                    fsum_reg[chi] <= aodbc_pkg::FSUM_MAX;
                else if (fadd < 41'(aodbc_pkg::FSUM_MIN))
                    fsum_reg[chi] <= aodbc_pkg::FSUM_MIN;
                else
                    fsum_reg[chi] <= fadd[39:0];
                bused_reg[chi] <= bused_reg[chi] + 16'd1;
            end
            // blank index advances once per blank item, at output time, until 0xFFFF
            if (state_reg == S_OUT && kind_reg == aodbc_pkg::KIND_BLANK && chok &&
                bidx_reg[chi] != 16'hFFFF)
                bidx_reg[chi] <= bidx_reg[chi] + 16'd1;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            kind_reg <= s_axis_tdata[1:0];
            ch_reg   <= s_axis_tdata[3:2];
            for (int k = 0; k < 6; k++)
                cnt_reg[k] <= s_axis_tdata[4 + k * CB +: CB];
            air_reg  <= s_axis_tuser;
            li_reg   <= 3'd0;
            dsum_reg <= '0;
            pass_reg <= 1'b0;
            od_reg   <= '0;
            ods_reg  <= '0;
            oda_reg  <= '0;
            conc_reg <= '0;
            cval_reg <= 1'b0;
            fault_reg <= 1'b0;
            fact_reg <= 32'sd1;     // marks "divider not yet started"
            t_reg    <= 64'd1;
        end
        case (state_reg)
            S_LOG:
            begin
                if (any_zero)
                    fault_reg <= 1'b1;
            end
            S_LWAIT:
            begin
                if (lrsp.done)
                begin
                    if (li_reg[1])
                        dsum_reg <= dsum_reg - 34'(lrsp.res);
                    else
                        dsum_reg <= dsum_reg + 34'(lrsp.res);
                    li_reg <= li_reg + 3'd1;
                end
            end
            S_MUL:
            begin
                if (pass_reg)
                    oda_reg <= p_neg ? -32'(rnd40) : 32'(rnd40);
                else
                begin
                    ods_reg <= p_neg ? -32'(rnd40) : 32'(rnd40);
                    od_reg  <= p_neg ? -32'(rnd40) : 32'(rnd40);
                end
                pass_reg <= 1'b1;
                li_reg   <= 3'd0;
                dsum_reg <= '0;
                fact_reg <= 32'sd65536;
                if (kind_reg == aodbc_pkg::KIND_MEASURE && air_reg && chok &&
                    bused_reg[chi] != 16'd0)
                    fact_reg <= 32'sd1;
            end
            S_FDIV:
            begin
                if (air_reg && oda_reg == 32'sd0)
                begin
                    fault_reg <= 1'b1;
                    od_reg    <= '0;
                end
            end
            S_FACC:
            begin
                if (drsp.done)
                    fact_reg <= q_sat[31:0];
            end
            S_MDIV:
            begin
                if (dreq.start)
                    fact_reg <= 32'sd0;
                else if (drsp.done)
                begin
                    if (drsp.quo > 64'd2147483648)
                        fact_reg <= fsum_reg[chi][39] ? -32'sd2147483648 : 32'sd2147483647;
                    else if (!fsum_reg[chi][39] && drsp.quo == 64'd2147483648)
                        fact_reg <= 32'sd2147483647;
                    else
                        fact_reg <= fsum_reg[chi][39] ? -32'(drsp.quo) : 32'(drsp.quo);
                end
            end
            S_CORR:
            begin
                if (corr_diff > 66'sd2147483647)
                    od_reg <= 32'sd2147483647;
                else if (corr_diff < -66'sd2147483648)
                    od_reg <= -32'sd2147483648;
                else
                    od_reg <= corr_diff[31:0];
                if (ch_reg == aodbc_pkg::CH_260)
                    cval_reg <= 1'b1;
            end
            S_CDIV:
            begin
                if (od_reg != 32'sd0 && path_reg == 24'd0)
                    conc_reg <= od_reg[31] ? aodbc_pkg::CONC_MIN : aodbc_pkg::CONC_MAX;
                else if (dreq.start)
                    t_reg <= 64'd0;
                else if (drsp.done)
                    t_reg <= drsp.quo;
            end
            S_CMUL:
            begin
                if (hi_prod >= (57'd1 << 38))
                    conc_reg <= od_reg[31] ? aodbc_pkg::CONC_MIN : aodbc_pkg::CONC_MAX;
                else
                begin
                    logic [63:0] r;
                    r = (64'(hi_a) << 10) + 64'(p_mag[65:16]);
                    if (!od_reg[31])
                        conc_reg <= (r > 64'(aodbc_pkg::CONC_MAX)) ?
                                    aodbc_pkg::CONC_MAX : r[47:0];
                    else
                        conc_reg <= (r > 64'(aodbc_pkg::CONC_MAX) + 64'd1) ?
                                    aodbc_pkg::CONC_MIN : 48'(-r);
                end
            end
            S_OUT:
            begin
                out_reg <= {6'd0, fault_reg, cval_reg & ~fault_reg,
                            fault_reg ? 48'd0 : conc_reg,
                            fault_reg ? 32'd0 : od_reg};
            end
            default: ;
        endcase
    end

    // no input taken while a result is pending
    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> !s_axis_tready)
        else $error("input accepted with result pending");

    // a result only comes out of the output state
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output state");

    // faulted results carry no concentration flag
    a_fault_noconc: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && out_reg[81] |-> !out_reg[80])
        else $error("fault with valid concentration");

endmodule

// ----- sim/absorbance_od_with_blank_correction_tb.sv -----
// Self-checking testbench for absorbance_od_with_blank_correction.
// Depends on aodbc_pkg and the block; a directed table, then random phases under
// several register settings, checked against a built-in fixed-point OD predictor.
module absorbance_od_with_blank_correction_tb;

    // one measurement transaction as packed into s_axis_tdata / tuser
    typedef struct packed {
        aodbc_pkg::kind_t kind;
        logic [1:0]  ch;
        logic [23:0] base_s;
        logic [23:0] base_r;
        logic [23:0] meas_s;
        logic [23:0] meas_r;
        logic [23:0] air_s;
        logic [23:0] air_r;
        logic        air;
    } od_item_t;

    typedef struct packed {
        logic [31:0] od;
        logic [47:0] conc;
        logic        conc_ok;
        logic        flt;
    } od_result_t;

    // directed row: item plus an optional hand-written result
    typedef struct packed {
        od_item_t   it;
        logic       fixed;
        od_result_t res;
    } dir_row_t;

    localparam int DRAIN_CYCLES = 400;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata = '0;     // kind, channel, 6 counts, zero pad
    logic         s_axis_tuser = 1'b0;   // has_air
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [87:0]  m_axis_tdata;          // od, concentration, conc_valid, fault
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = aodbc_pkg::CFG_PATH;
    logic [31:0]  cfg_data = '0;

    // tag travelling with the driven transaction
    logic         drv_fixed = 1'b0;
    od_result_t   drv_res = '0;
    bit           quiet = 1'b0;

    od_result_t   od_expect_q[$];
    int           errs = 0;
    int           mism = 0;

    // predictor copy of registers and per-channel blank state
    longint unsigned path_len = 65536;
    longint unsigned a260 = 3276800;
    longint unsigned blank_lim = 1;
    longint          fsum[4];
    int unsigned     blank_idx[4];
    int unsigned     blank_used[4];

    absorbance_od_with_blank_correction u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic longint clampv(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint unsigned magv(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint signv(longint unsigned m, bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // round half away from zero
    function automatic longint round_shift(longint v, int s);
        longint unsigned m;
        m = (magv(v) + (64'd1 << (s - 1))) >> s;
        return signv(m, v < 0);
    endfunction

    // log2 by repeated squaring, 24 fraction bits
    function automatic longint log2_fix(longint unsigned x);
        int n;
        longint unsigned m;
        longint r;
        n = 0;
        while (n < 31 && (x >> (n + 1)) != 0)
            n++;
        m = x << (31 - n);
        r = n;
        for (int i = 0; i < aodbc_pkg::LOG_FRAC; i++)
        begin
            m = (m * m) >> 31;
            r = r <<< 1;
            if (m >= 64'h1_0000_0000)
            begin
                m = m >> 1;
                r = r | 1;
            end
        end
        return r;
    endfunction

    function automatic longint od_of(longint unsigned bs, longint unsigned br,
                                     longint unsigned ms, longint unsigned mr);
        longint d;
        d = log2_fix(bs) + log2_fix(mr) - log2_fix(br) - log2_fix(ms);
        return round_shift(d * longint'(aodbc_pkg::LOG10_2_Q32), 40);
    endfunction

    function automatic longint conc_of(longint od);
        longint unsigned t, hi, lo, r;
        if (od == 0)
            return 0;
        if (path_len == 0)
            return od > 0 ? longint'(aodbc_pkg::CONC_MAX) : longint'(aodbc_pkg::CONC_MIN);
        t = ((magv(od) * 10) << 16) / path_len;
        hi = t >> 26;
        lo = t & ((64'd1 << 26) - 1);
        if (hi * a260 >= (64'd1 << 38))
            return od > 0 ? longint'(aodbc_pkg::CONC_MAX) : longint'(aodbc_pkg::CONC_MIN);
        r = ((hi * a260) << 10) + ((lo * a260) >> 16);
        if (od > 0)
            return r > longint'(aodbc_pkg::CONC_MAX) ?
                   longint'(aodbc_pkg::CONC_MAX) : longint'(r);
        return r > longint'(aodbc_pkg::CONC_MAX) + 1 ?
               longint'(aodbc_pkg::CONC_MIN) : -longint'(r);
    endfunction

    // updates blank state; returns 1 when the item yields a result
    function automatic bit predict_od(od_item_t it, output od_result_t r);
        bit flt;
        longint ods, oda, od, q, f, conc;
        r = '0;
        ods = 0; oda = 0; od = 0; conc = 0;
        if (it.kind == aodbc_pkg::KIND_CLEAR)
        begin
            for (int c = 0; c < 4; c++)
            begin
                fsum[c] = 0;
                blank_idx[c] = 0;
                blank_used[c] = 0;
            end
            return 0;
        end
        if (it.kind == aodbc_pkg::KIND_NONE)
            return 0;
        flt = it.base_s == 0 || it.base_r == 0 || it.meas_s == 0 || it.meas_r == 0 ||
              (it.air && (it.air_s == 0 || it.air_r == 0));
        if (!flt)
        begin
            ods = od_of(it.base_s, it.base_r, it.meas_s, it.meas_r);
            if (it.air)
                oda = od_of(it.base_s, it.base_r, it.air_s, it.air_r);
        end
        if (it.kind == aodbc_pkg::KIND_BLANK)
        begin
            if (!flt && it.air && oda == 0)
                flt = 1;
            if (!flt)
                od = ods;
            if (!flt && it.air && blank_idx[it.ch] < blank_lim)
            begin
                q = signv((magv(ods) << 16) / magv(oda), (ods < 0) != (oda < 0));
                q = clampv(q, -64'sd2147483648, 64'sd2147483647);
                fsum[it.ch] = clampv(fsum[it.ch] + q, aodbc_pkg::FSUM_MIN,
                                     aodbc_pkg::FSUM_MAX);
                blank_used[it.ch]++;
            end
            if (blank_idx[it.ch] < 65535)
                blank_idx[it.ch]++;
        end
        else if (!flt)
        begin
            if (it.air)
            begin
                f = 65536;
                if (blank_used[it.ch] != 0)
                    f = clampv(fsum[it.ch] / longint'(blank_used[it.ch]),
                               -64'sd2147483648, 64'sd2147483647);
                od = clampv(ods - round_shift(oda * f, 16),
                            -64'sd2147483648, 64'sd2147483647);
                if (it.ch == aodbc_pkg::CH_260)
                begin
                    r.conc_ok = 1'b1;
                    conc = conc_of(od);
                end
            end
            else
                od = ods;
        end
        r.od = od[31:0];
        r.conc = conc[47:0];
        r.flt = flt;
        return 1;
    endfunction

    // scoreboard: predict on input transaction, compare on output transaction
    always @(posedge clk)
    begin
        od_result_t p, got;
        if (s_axis_tvalid && s_axis_tready)
        begin
            if (predict_od({aodbc_pkg::kind_t'(s_axis_tdata[1:0]), s_axis_tdata[3:2],
                            s_axis_tdata[27:4], s_axis_tdata[51:28],
                            s_axis_tdata[75:52], s_axis_tdata[99:76],
                            s_axis_tdata[123:100], s_axis_tdata[147:124],
                            s_axis_tuser}, p))
                od_expect_q.push_back(drv_fixed ? drv_res : p);
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[31:0], m_axis_tdata[79:32], m_axis_tdata[80],
                   m_axis_tdata[81]};
            if (od_expect_q.size() == 0)
            begin
                errs++;
                if (mism++ < 10)
                    $display("unexpected result od=%h conc=%h cv=%b flt=%b",
                             got.od, got.conc, got.conc_ok, got.flt);
            end
            else
            begin
                p = od_expect_q.pop_front();
                if (got !== p)
                begin
                    errs++;
                    if (mism++ < 10)
                        $display({"mismatch: od exp %h got %h, conc exp %h got %h, ",
                                  "cv exp %b got %b, flt exp %b got %b"},
                                 p.od, got.od, p.conc, got.conc, p.conc_ok, got.conc_ok,
                                 p.flt, got.flt);
                end
            end
        end
    end

    // sink stalls about a quarter of the cycles, none while quiet
    always @(posedge clk)
        m_axis_tready <= quiet || ($urandom_range(99) >= 26);

    task automatic send(od_item_t it, logic fixed, od_result_t res);
        while (!quiet && $urandom_range(99) < 26)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, it.air_r, it.air_s, it.meas_r, it.meas_s,
                         it.base_r, it.base_s, it.ch, it.kind};
        s_axis_tuser <= it.air;
        drv_fixed <= fixed;
        drv_res <= res;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // wait out every pending result plus block latency
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (od_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            aodbc_pkg::CFG_PATH:  path_len = val[23:0];
            aodbc_pkg::CFG_A260:  a260 = val;
            aodbc_pkg::CFG_BLANK: blank_lim = val[15:0];
            default: ;
        endcase
    endtask

    function automatic logic [23:0] rand_count();
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return 24'd0;
        if (r < 10)
            return 24'hFFFFFF;
        if (r < 25)
            return 24'($urandom_range(255, 1));
        return 24'($urandom_range(24'hFFFFFF, 1));
    endfunction

    function automatic od_item_t rand_item();
        od_item_t it;
        int r;
        int unsigned lvl;
        r = $urandom_range(99);
        it.kind = r < 44 ? aodbc_pkg::KIND_BLANK : (r < 93 ? aodbc_pkg::KIND_MEASURE :
                  (r < 97 ? aodbc_pkg::KIND_CLEAR : aodbc_pkg::KIND_NONE));
        it.ch = 2'($urandom_range(3));
        it.air = $urandom_range(99) < 80;
        if ($urandom_range(1))
        begin
            // realistic readings: counts near one level, sample counts scaled down
            lvl = $urandom_range(24'hFF0000, 24'h100);
            it.base_s = 24'(lvl + $urandom_range(255));
            it.base_r = 24'(lvl + $urandom_range(255));
            it.meas_s = 24'(lvl / $urandom_range(8, 1) + 1);
            it.meas_r = 24'(lvl + $urandom_range(255));
            it.air_s = 24'(lvl / $urandom_range(3, 1) + $urandom_range(7));
            it.air_r = 24'(lvl + $urandom_range(255));
        end
        else
        begin
            it.base_s = rand_count();
            it.base_r = rand_count();
            it.meas_s = rand_count();
            it.meas_r = rand_count();
            it.air_s = rand_count();
            it.air_r = rand_count();
        end
        return it;
    endfunction

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            send(rand_item(), 1'b0, '0);
    endtask

    dir_row_t dir_tab[18];

    initial
    begin
        for (int c = 0; c < 4; c++)
        begin
            fsum[c] = 0;
            blank_idx[c] = 0;
            blank_used[c] = 0;
        end
        dir_tab = '{
            // blank with zero air OD: fault
            '{'{aodbc_pkg::KIND_BLANK, 2'd0, 24'd1000, 24'd1000, 24'd1000, 24'd1000,
                24'd1000, 24'd1000, 1'b1}, 1'b1, '{32'd0, 48'd0, 1'b0, 1'b1}},
            // zero count: fault
            '{'{aodbc_pkg::KIND_MEASURE, 2'd1, 24'd0, 24'd5, 24'd5, 24'd5, 24'd5, 24'd5,
                1'b1}, 1'b1, '{32'd0, 48'd0, 1'b0, 1'b1}},
            // zero air count ignored without air
            '{'{aodbc_pkg::KIND_MEASURE, 2'd2, 24'd5, 24'd5, 24'd5, 24'd5, 24'd0, 24'd7,
                1'b0}, 1'b1, '{32'd0, 48'd0, 1'b0, 1'b0}},
            // measure with zero air OD: no fault, concentration 0
            '{'{aodbc_pkg::KIND_MEASURE, 2'd1, 24'd100, 24'd100, 24'd100, 24'd100,
                24'd100, 24'd100, 1'b1}, 1'b1, '{32'd0, 48'd0, 1'b1, 1'b0}},
            '{'{aodbc_pkg::KIND_BLANK, 2'd1, 24'hFFFFFF, 24'd1, 24'd1, 24'hFFFFFF, 24'd1,
                24'hFFFFFF, 1'b1}, 1'b0, '0},
            '{'{aodbc_pkg::KIND_BLANK, 2'd1, 24'd1, 24'hFFFFFF, 24'hFFFFFF, 24'd1,
                24'hFFFFFF, 24'd1, 1'b1}, 1'b0, '0},
            '{'{aodbc_pkg::KIND_BLANK, 2'd0, 24'd1000, 24'd2000, 24'd3000, 24'd4000,
                24'd1500, 24'd2500, 1'b1}, 1'b0, '0},
            '{'{aodbc_pkg::KIND_MEASURE, 2'd0, 24'd1000, 24'd2000, 24'd3100, 24'd4000,
                24'd1600, 24'd2500, 1'b1}, 1'b0, '0},
            '{'{aodbc_pkg::KIND_MEASURE, 2'd1, 24'd500000, 24'd400000, 24'd30000,
                24'd600000, 24'd450000, 24'd390000, 1'b1}, 1'b0, '0},
            '{'{aodbc_pkg::KIND_MEASURE, 2'd1, 24'hFFFFFF, 24'd1, 24'd1, 24'hFFFFFF,
                24'hFFFFFF, 24'hFFFFFF, 1'b1}, 1'b0, '0},
            '{'{aodbc_pkg::KIND_MEASURE, 2'd1, 24'd1, 24'hFFFFFF, 24'hFFFFFF, 24'd1,
                24'd1, 24'd1, 1'b1}, 1'b0, '0},
            // clear and unused kind: no result
            '{'{aodbc_pkg::KIND_CLEAR, 2'd3, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1}, 1'b0, '0},
            '{'{aodbc_pkg::KIND_NONE, 2'd2, 24'd9, 24'd9, 24'd9, 24'd9, 24'd9, 24'd9,
                1'b0}, 1'b0, '0},
            // after clear the factor falls back to 1.0
            '{'{aodbc_pkg::KIND_MEASURE, 2'd1, 24'd500000, 24'd400000, 24'd30000,
                24'd600000, 24'd450000, 24'd390000, 1'b1}, 1'b0, '0},
            '{'{aodbc_pkg::KIND_BLANK, 2'd2, 24'd10, 24'd20, 24'd30, 24'd40, 24'd50,
                24'd60, 1'b0}, 1'b0, '0},
            '{'{aodbc_pkg::KIND_MEASURE, 2'd2, 24'd10, 24'd20, 24'd35, 24'd40, 24'd50,
                24'd60, 1'b0}, 1'b0, '0},
            // zero air count with air: fault
            '{'{aodbc_pkg::KIND_BLANK, 2'd3, 24'd5, 24'd5, 24'd5, 24'd5, 24'd5, 24'd0,
                1'b1}, 1'b1, '{32'd0, 48'd0, 1'b0, 1'b1}},
            '{'{aodbc_pkg::KIND_MEASURE, 2'd3, 24'd5, 24'd5, 24'd5, 24'd5, 24'd0, 24'd5,
                1'b1}, 1'b1, '{32'd0, 48'd0, 1'b0, 1'b1}}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at reset defaults
        foreach (dir_tab[i])
            send(dir_tab[i].it, dir_tab[i].fixed, dir_tab[i].res);
        drain();

        // shortest path, largest unit, no blanks used
        cfg_write(aodbc_pkg::CFG_PATH, 32'd1);
        cfg_write(aodbc_pkg::CFG_A260, 32'hFFFFFFFF);
        cfg_write(aodbc_pkg::CFG_BLANK, 32'd0);
        run_random(300);
        drain();

        // longest path, zero unit, every blank used; no idling on either side
        cfg_write(aodbc_pkg::CFG_PATH, 32'hFFFFFF);
        cfg_write(aodbc_pkg::CFG_A260, 32'd0);
        cfg_write(aodbc_pkg::CFG_BLANK, 32'hFFFF);
        quiet = 1'b1;
        run_random(300);
        quiet = 1'b0;
        drain();

        // zero path length: concentration saturates
        cfg_write(aodbc_pkg::CFG_PATH, 32'd0);
        cfg_write(aodbc_pkg::CFG_A260, $urandom);
        cfg_write(aodbc_pkg::CFG_BLANK, 32'd3);
        run_random(200);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            cfg_write(aodbc_pkg::CFG_PATH, $urandom_range(24'hFFFFFF, 1));
            cfg_write(aodbc_pkg::CFG_A260, $urandom_range(32'h0100_0000));
            cfg_write(aodbc_pkg::CFG_BLANK, $urandom_range(8));
            run_random(200);
            drain();
        end

        errs += od_expect_q.size();
        if (errs == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
